>>> hw/rtl/rpmt_pkg.sv
// ----------------------------------------------------------------------------
// rpmt_pkg: shared types and constants for the RP mapping table
// Request codes, status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package rpmt_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned LEN_W   = 8;
   localparam int unsigned HOLD_W  = 16;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned SLEN_W  = 6;
   localparam int unsigned MAX_LEN = 32;

   localparam logic [1:0] REQ_LEARN = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_AGE   = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_BADLEN = 2'd1;
   localparam logic [1:0] ST_NOTGRP = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [3:0] GROUP_NIBBLE = 4'hE;

   localparam logic [0:0] CSR_TABLE_LIMIT = 1'd0;
   localparam logic [0:0] CSR_AGE_STEP    = 1'd1;

   // Classified transaction handed from the front to the back.
   typedef struct packed {
      logic [1:0]          kind;
      logic                reject;
      logic [1:0]          rej_status;
      logic [ADDR_W-1:0]   key;
      logic [ADDR_W-1:0]   group;
      logic [SLEN_W-1:0]   len;
      logic                deny;
      logic [HOLD_W-1:0]   hold;
      logic [ADDR_W-1:0]   agent;
   } cmd_type;

   function automatic logic [ADDR_W-1:0] len_to_mask(input logic [SLEN_W-1:0] len);
      logic [ADDR_W:0] wide;
      wide = {(ADDR_W+1){1'b1}} << (ADDR_W - 32'(len));
      return wide[ADDR_W-1:0] & ~(len == '0 ? {ADDR_W{1'b1}} : {ADDR_W{1'b0}});
   endfunction

endpackage

>>> hw/rtl/rpmt_front.sv
// ----------------------------------------------------------------------------
// rpmt_front: request classifier
// Checks mask length and group range, masks the prefix, builds the key and
// pushes the command into a two-entry queue.
// ----------------------------------------------------------------------------
module rpmt_front import rpmt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [ADDR_W-1:0] req_rp_addr,
   input  logic [ADDR_W-1:0] req_group_addr,
   input  logic [LEN_W-1:0]  req_prefix_len,
   input  logic              req_is_deny,
   input  logic [HOLD_W-1:0] req_hold_secs,
   input  logic [ADDR_W-1:0] req_agent_addr,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  logic              cmd_take
);

   cmd_type    q_ff [2];
   cmd_type    new_cmd;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic [ADDR_W-1:0] mask, grp;

   always_comb begin
      mask = len_to_mask(req_prefix_len[SLEN_W-1:0]);
      grp  = req_group_addr & mask;
      new_cmd.kind       = req_type;
      new_cmd.reject     = 1'b0;
      new_cmd.rej_status = ST_DONE;
      new_cmd.key        = req_is_deny ? '0 : req_rp_addr;
      new_cmd.group      = (req_type == REQ_LEARN) ? grp : req_group_addr;
      new_cmd.len        = req_prefix_len[SLEN_W-1:0];
      new_cmd.deny       = req_is_deny;
      new_cmd.hold       = req_hold_secs;
      new_cmd.agent      = req_agent_addr;
      if (req_type == REQ_LEARN) begin
         if (req_prefix_len > LEN_W'(MAX_LEN)) begin
            new_cmd.reject     = 1'b1;
            new_cmd.rej_status = ST_BADLEN;
         end else if (grp[ADDR_W-1 -: 4] != GROUP_NIBBLE) begin
            new_cmd.reject     = 1'b1;
            new_cmd.rej_status = ST_NOTGRP;
         end
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ cmd_take;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("take from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> req_stall) else $error("full queue not stalled");

endmodule

>>> hw/rtl/rpmt_back.sv
// ----------------------------------------------------------------------------
// rpmt_back: table walker
// Walks every slot once per learn, query or age, one slot a cycle, then
// commits and posts to the output register; clear and rejects skip the walk.
// ----------------------------------------------------------------------------
module rpmt_back import rpmt_pkg::*; #(
   parameter int unsigned ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_take,
   input  logic [CNT_W-1:0]  table_limit,
   input  logic [HOLD_W-1:0] age_step,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic              rsp_denied,
   output logic [CNT_W-1:0]  rsp_entry_count
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CTR_W = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_WRITE = 4'b0100,
      S_POST  = 4'b1000
   } state_type;

   // Table memories, one slot read per cycle.
   logic [ADDR_W-1:0] m_rp     [ENTRIES];
   logic [ADDR_W-1:0] m_prefix [ENTRIES];
   logic [SLEN_W-1:0] m_len    [ENTRIES];
   logic              m_deny   [ENTRIES];
   logic [HOLD_W-1:0] m_hold   [ENTRIES];
   logic [ADDR_W-1:0] m_agent  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   state_type         st_ff, st_in;
   cmd_type           c_ff;
   logic [CTR_W-1:0]  idx_ff, idx_in;     // address issued
   logic [IDX_W-1:0]  ridx_ff;            // address of data now in rd_*
   logic              rv_ff;              // rd_* holds a slot
   logic [ADDR_W-1:0] rd_rp, rd_prefix;
   logic [SLEN_W-1:0] rd_len;
   logic              rd_deny;
   logic [HOLD_W-1:0] rd_hold;

   logic              hit_ff, free_ff, best_v_ff, verdict_ff;
   logic [IDX_W-1:0]  hit_idx_ff, free_idx_ff;
   logic [SLEN_W-1:0] best_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [1:0]        status_ff;
   logic              denied_ff;

   // Result register, held while the consumer stalls.
   logic [1:0]        out_status_ff;
   logic              out_denied_ff;
   logic [CNT_W-1:0]  out_count_ff;

   logic              slot_v, match, qmatch;
   logic [ADDR_W-1:0] qmask;
   logic              out_free;

   assign out_free = !rsp_valid || !rsp_stall;
   assign cmd_take = (st_ff == S_IDLE) && cmd_valid;
   assign rsp_status      = out_status_ff;
   assign rsp_denied      = out_denied_ff;
   assign rsp_entry_count = out_count_ff;

   always_comb begin
      slot_v = valid_ff[ridx_ff] && rv_ff;
      match  = slot_v && rd_rp == c_ff.key && rd_prefix == c_ff.group
               && rd_len == c_ff.len;
      qmask  = len_to_mask(rd_len);
      qmatch = slot_v && ((c_ff.group & qmask) == (rd_prefix & qmask));
   end

   always_comb begin
      st_in  = st_ff;
      idx_in = idx_ff;
      unique case (st_ff)
         S_IDLE: begin
            idx_in = '0;
            if (cmd_valid) begin
               if (cmd.kind == REQ_CLEAR || cmd.reject) st_in = S_POST;
               else st_in = S_WALK;
            end
         end
         S_WALK: begin
            if (idx_ff != CTR_W'(ENTRIES)) idx_in = idx_ff + 1'b1;
            if (rv_ff && ridx_ff == IDX_W'(ENTRIES - 1)) st_in = S_WRITE;
         end
         S_WRITE: st_in = S_POST;
         S_POST:  if (out_free) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // Registered slot read.
      rd_rp     <= m_rp[idx_ff[IDX_W-1:0]];
      rd_prefix <= m_prefix[idx_ff[IDX_W-1:0]];
      rd_len    <= m_len[idx_ff[IDX_W-1:0]];
      rd_deny   <= m_deny[idx_ff[IDX_W-1:0]];
      rd_hold   <= m_hold[idx_ff[IDX_W-1:0]];
      ridx_ff   <= idx_ff[IDX_W-1:0];
      if (cmd_take) c_ff <= cmd;

      // Aging write-back of the slot just read.
      if (st_ff == S_WALK && c_ff.kind == REQ_AGE && slot_v && rd_hold != '0
          && rd_hold > age_step) begin
         m_hold[ridx_ff] <= rd_hold - age_step;
      end
      // Learn commit.
      if (st_ff == S_WRITE && c_ff.kind == REQ_LEARN) begin
         if (hit_ff) begin
            m_deny[hit_idx_ff]  <= c_ff.deny;
            m_hold[hit_idx_ff]  <= c_ff.hold;
            m_agent[hit_idx_ff] <= c_ff.agent;
         end else if (free_ff && count_ff < table_limit) begin
            m_rp[free_idx_ff]     <= c_ff.key;
            m_prefix[free_idx_ff] <= c_ff.group;
            m_len[free_idx_ff]    <= c_ff.len;
            m_deny[free_idx_ff]   <= c_ff.deny;
            m_hold[free_idx_ff]   <= c_ff.hold;
            m_agent[free_idx_ff]  <= c_ff.agent;
         end
      end

      if (reset) begin
         st_ff         <= S_IDLE;
         idx_ff        <= '0;
         rv_ff         <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_valid     <= 1'b0;
         status_ff     <= ST_DONE;
         denied_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         best_v_ff     <= 1'b0;
         verdict_ff    <= 1'b0;
         out_status_ff <= ST_DONE;
         out_denied_ff <= 1'b0;
         out_count_ff  <= '0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         rv_ff  <= (st_ff == S_WALK) && (idx_ff != CTR_W'(ENTRIES));
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               hit_ff     <= 1'b0;
               free_ff    <= 1'b0;
               best_v_ff  <= 1'b0;
               verdict_ff <= 1'b0;
               status_ff  <= ST_DONE;
               if (cmd_valid && cmd.kind == REQ_CLEAR) begin
                  valid_ff <= '0;
                  count_ff <= '0;
               end
               if (cmd_valid && cmd.reject) status_ff <= cmd.rej_status;
            end
            S_WALK: begin
               // Scan state per slot; keep the lowest hit and free slot.
               if (c_ff.kind == REQ_LEARN && rv_ff) begin
                  if (match && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= ridx_ff;
                  end
                  if (!valid_ff[ridx_ff] && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= ridx_ff;
                  end
               end
               if (c_ff.kind == REQ_QUERY && qmatch) begin
                  if (!best_v_ff || rd_len > best_ff) begin
                     best_v_ff  <= 1'b1;
                     best_ff    <= rd_len;
                     verdict_ff <= rd_deny;
                  end else if (rd_len == best_ff && rd_deny) begin
                     verdict_ff <= 1'b1;
                  end
               end
               if (c_ff.kind == REQ_AGE && slot_v && rd_hold != '0
                   && rd_hold <= age_step) begin
                  valid_ff[ridx_ff] <= 1'b0;
                  if (count_ff != '0) count_ff <= count_ff - 1'b1;
               end
            end
            S_WRITE: begin
               if (c_ff.kind == REQ_LEARN && !hit_ff) begin
                  if (free_ff && count_ff < table_limit) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     status_ff <= ST_FULL;
                  end
               end
               denied_ff <= 1'b0;
               if (c_ff.kind == REQ_QUERY) denied_ff <= verdict_ff;
            end
            S_POST: begin
               // Load the result register once the previous result is gone.
               if (out_free) begin
                  rsp_valid     <= 1'b1;
                  out_status_ff <= status_ff;
                  out_denied_ff <= (c_ff.kind == REQ_QUERY) ? denied_ff : 1'b0;
                  out_count_ff  <= count_ff;
               end
            end
            default: ;
         endcase
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> st_ff == S_IDLE) else $error("take while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= ENTRIES) else $error("count above depth");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff)) else $error("state not one-hot");
   a_post: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_POST && out_free) |=> rsp_valid) else $error("result lost");

endmodule

>>> hw/rtl/rp_mapping_table_with_deny_match_core.sv
// ----------------------------------------------------------------------------
// rp_mapping_table_with_deny_match_core: group-prefix mapping table
// Learn, longest-match deny query, aging tick and clear over a slot table.
// ----------------------------------------------------------------------------
// Each transaction yields exactly one result. Learn, query and tick walk all
// ENTRIES slots through the single read port of the slot memory; a clear or
// a rejected learn skips the walk. The front classifies and queues up to two
// transactions, so a new request is taken while the back walks the table as
// long as the queue has room, and the result register lets the walk finish
// while the consumer stalls. Clear drops every valid bit at once; there is no
// clearing pass after reset. Configuration writes must be made only while the
// block is idle.
module rp_mapping_table_with_deny_match_core import rpmt_pkg::*; #(
   parameter int unsigned ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [HOLD_W-1:0] csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [ADDR_W-1:0] req_rp_addr,
   input  logic [ADDR_W-1:0] req_group_addr,
   input  logic [LEN_W-1:0]  req_prefix_len,
   input  logic              req_is_deny,
   input  logic [HOLD_W-1:0] req_hold_secs,
   input  logic [ADDR_W-1:0] req_agent_addr,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic              rsp_denied,
   output logic [CNT_W-1:0]  rsp_entry_count
);

   logic [CNT_W-1:0]  table_limit_ff;
   logic [HOLD_W-1:0] age_step_ff;
   logic              cmd_valid, cmd_take;
   cmd_type           cmd;

   // Hold the configuration registers; write only when idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         table_limit_ff <= CNT_W'(64);
         age_step_ff    <= HOLD_W'(5);
      end else if (csr_write) begin
         if (csr_index == CSR_TABLE_LIMIT) table_limit_ff <= csr_data[CNT_W-1:0];
         else age_step_ff <= csr_data;
      end
   end

   rpmt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_rp_addr,
      .req_group_addr, .req_prefix_len, .req_is_deny, .req_hold_secs,
      .req_agent_addr, .cmd_valid, .cmd, .cmd_take
   );

   rpmt_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take,
      .table_limit (table_limit_ff),
      .age_step    (age_step_ff),
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_denied, .rsp_entry_count
   );

endmodule
